@@ rtl/bpa_pkg.sv @@
package bpa_pkg;

   // Request codes as they arrive on req_type
   typedef enum logic [1:0] {
      REQ_ALLOC   = 2'd0,
      REQ_FREE    = 2'd1,
      REQ_ADD     = 2'd2,
      REQ_UNKNOWN = 2'd3
   } req_kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NO_BLOCK = 2'd1,
      ST_BAD      = 2'd2,
      ST_IGNORED  = 2'd3
   } status_type;

   // Work handed from the front end to the engine
   typedef enum logic [1:0] {
      CMD_ALLOC,
      CMD_FREE,
      CMD_ADD,
      CMD_REPORT
   } cmd_kind_type;

   localparam int FRAME_W     = 16;
   localparam int END_W       = 17;
   localparam int COUNT_W     = 17;
   localparam int ORD_W       = 5;
   localparam int QUEUE_DEPTH = 2;
   localparam int WORD_W      = 32;
   localparam int WORD_SH     = 5;

   typedef struct packed {
      cmd_kind_type         kind;
      status_type           status;
      logic [ORD_W-1:0]     ord;
      logic [FRAME_W-1:0]   frame;
      logic [END_W-1:0]     end_frame;
   } cmd_type;

   // Engine sequencer states
   typedef enum logic [4:0] {
      E_INIT,
      E_IDLE,
      E_SRCH,
      E_POP_WAIT,
      E_SPLIT,
      E_FILL,
      E_FILL_WR,
      E_MERGE,
      E_SCAN_RD,
      E_SCAN_CHK,
      E_RM,
      E_RM_HEAD,
      E_RM_CHK,
      E_RM_UNLINK,
      E_PUSH,
      E_ADD,
      E_DONE
   } eng_state_type;

endpackage

@@ rtl/bpa_front.sv @@
module bpa_front #(
   parameter int NUM_FRAMES = 65536,
   parameter int TOP_ORDER  = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_type,
   input  logic [15:0]                      req_page_count,
   input  logic [15:0]                      req_frame,
   input  logic [16:0]                      req_end_frame,
   input  logic [$clog2(NUM_FRAMES):0]      lim,
   input  logic                             init_busy,
   output logic                             cmd_valid,
   input  logic                             cmd_ready,
   output bpa_pkg::cmd_type                 cmd
);

   localparam int QPW = $clog2(bpa_pkg::QUEUE_DEPTH);

   bpa_pkg::cmd_type                 q_ff [bpa_pkg::QUEUE_DEPTH];
   logic [QPW-1:0]                   wr_ptr_ff, wr_ptr_in;
   logic [QPW-1:0]                   rd_ptr_ff, rd_ptr_in;
   logic [QPW:0]                     count_ff, count_in;
   logic                             push, pop;
   logic [15:0]                      m;
   logic [bpa_pkg::ORD_W-1:0]        ord_raw;
   logic [31:0]                      np, base32, lim32, end32, endc;
   logic                             bad;
   bpa_pkg::cmd_type                 cmd_new;

   // Classify the incoming beat
   always_comb begin
      m       = req_page_count - 16'd1;
      ord_raw = '0;
      for (int i = 0; i < 16; i++) begin
         if (m[i]) ord_raw = bpa_pkg::ORD_W'(i + 1);
      end
      np     = 32'd1 << ord_raw;
      base32 = 32'(req_frame);
      lim32  = 32'(lim);
      end32  = 32'(req_end_frame);
      bad    = (req_page_count == 16'd0) || (ord_raw > bpa_pkg::ORD_W'(TOP_ORDER));
      endc   = (end32 > lim32) ? lim32 : end32;

      cmd_new.kind      = bpa_pkg::CMD_REPORT;
      cmd_new.status    = bpa_pkg::ST_DONE;
      cmd_new.ord       = ord_raw;
      cmd_new.frame     = req_frame;
      cmd_new.end_frame = endc[16:0];
      case (bpa_pkg::req_kind_type'(req_type))
         bpa_pkg::REQ_ALLOC: begin
            if (bad) cmd_new.status = bpa_pkg::ST_BAD;
            else     cmd_new.kind   = bpa_pkg::CMD_ALLOC;
         end
         bpa_pkg::REQ_FREE: begin
            if (bad) cmd_new.status = bpa_pkg::ST_BAD;
            else if (base32 >= lim32 || base32 + np > lim32)
               cmd_new.status = bpa_pkg::ST_IGNORED;
            else cmd_new.kind = bpa_pkg::CMD_FREE;
         end
         bpa_pkg::REQ_ADD: begin
            if (endc > base32) cmd_new.kind = bpa_pkg::CMD_ADD;
         end
         default: cmd_new.status = bpa_pkg::ST_IGNORED;
      endcase
   end

   // Short queue towards the engine
   assign req_ready = (count_ff != (QPW+1)'(bpa_pkg::QUEUE_DEPTH)) && !init_busy;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= cmd_new;
   end

endmodule

@@ rtl/bpa_engine.sv @@
module bpa_engine #(
   parameter int NUM_FRAMES = 65536,
   parameter int TOP_ORDER  = 15
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [$clog2(NUM_FRAMES):0]      lim,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  bpa_pkg::cmd_type                 cmd,
   output logic                             init_busy,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [15:0]                      rsp_alloc_frame,
   output logic [16:0]                      rsp_free_pages,
   output logic [16:0]                      rsp_managed_pages
);

   localparam int FW  = $clog2(NUM_FRAMES);
   localparam int CW  = FW + 1;
   localparam int WAW = FW - bpa_pkg::WORD_SH;
   localparam int NW  = (NUM_FRAMES + bpa_pkg::WORD_W - 1) / bpa_pkg::WORD_W;
   localparam int OW  = (TOP_ORDER < 2) ? 1 : $clog2(TOP_ORDER + 1);
   localparam int HN  = TOP_ORDER + 1;
   localparam int OSW = bpa_pkg::ORD_W;

   // Memories: allocation bitmap in 32-bit words, next-link store
   logic [bpa_pkg::WORD_W-1:0] bm_mem [NW];
   logic [FW-1:0]              lk_mem [NUM_FRAMES];
   logic [bpa_pkg::WORD_W-1:0] bm_rdata_ff, bm_wdata;
   logic [WAW-1:0]             bm_waddr, bm_raddr;
   logic                       bm_we;
   logic [FW-1:0]              lk_rdata_ff, lk_wdata, lk_waddr, lk_raddr;
   logic                       lk_we;

   // Free list heads
   logic [FW-1:0] head_ff [HN];
   logic [31:0]   len_ff  [HN];
   logic [OW-1:0] hd_ridx, hd_widx;
   logic [FW-1:0] hd_rframe, hd_wframe;
   logic [31:0]   hd_rlen, hd_wlen;
   logic          hd_we;

   bpa_pkg::eng_state_type state_ff, state_in;
   bpa_pkg::cmd_kind_type  kind_ff, kind_in;
   bpa_pkg::status_type    status_ff, status_in;
   logic [WAW-1:0] w_ff, w_in;
   logic [FW-1:0]  lo_ff, lo_in;
   logic [CW-1:0]  hi_ff, hi_in;
   logic           fill_one_ff, fill_one_in;
   logic [FW-1:0]  base_ff, base_in;
   logic [OW-1:0]  ord_ff, ord_in;
   logic [OW-1:0]  o_ff, o_in;
   logic [FW-1:0]  buddy_ff, buddy_in;
   logic [FW-1:0]  prev_ff, prev_in;
   logic [31:0]    idx_ff, idx_in;
   logic [CW-1:0]  f_ff, f_in;
   logic [CW-1:0]  end_ff, end_in;
   logic [FW-1:0]  res_frame_ff, res_frame_in;
   logic [CW-1:0]  alloc_cnt_ff, alloc_cnt_in;
   logic [CW-1:0]  managed_cnt_ff, managed_cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [1:0]     rsp_status_ff, rsp_status_in;
   logic [15:0]    rsp_frame_ff, rsp_frame_in;
   logic [16:0]    rsp_free_ff, rsp_free_in;
   logic [16:0]    rsp_managed_ff, rsp_managed_in;

   // Word mask over the current range
   logic [WAW-1:0]             lo_word, hi_word;
   logic [FW-1:0]              hi_last;
   logic [4:0]                 lo_b, hi_b;
   logic [bpa_pkg::WORD_W-1:0] mask;
   logic                       fill_last;

   assign lo_word   = lo_ff[FW-1:bpa_pkg::WORD_SH];
   assign hi_last   = FW'(hi_ff - CW'(1));
   assign hi_word   = hi_last[FW-1:bpa_pkg::WORD_SH];
   assign lo_b      = (w_ff == lo_word) ? lo_ff[4:0] : 5'd0;
   assign hi_b      = (w_ff == hi_word) ? hi_last[4:0] : 5'd31;
   assign mask      = ({bpa_pkg::WORD_W{1'b1}} << lo_b) & ({bpa_pkg::WORD_W{1'b1}} >> (5'd31 - hi_b));
   assign fill_last = (w_ff == hi_word);

   // Largest aligned block that fits at f for region add
   logic [OSW-1:0] tz, fl, aord;
   logic [CW-1:0]  diff;
   always_comb begin
      tz = OSW'(CW);
      for (int i = CW - 1; i >= 0; i--) begin
         if (f_ff[i]) tz = OSW'(i);
      end
      diff = end_ff - f_ff;
      fl   = '0;
      for (int i = 0; i < CW; i++) begin
         if (diff[i]) fl = OSW'(i);
      end
      aord = (tz < fl) ? tz : fl;
      if (aord > OSW'(TOP_ORDER)) aord = OSW'(TOP_ORDER);
   end

   // Head read port address
   always_comb begin
      case (state_ff)
         bpa_pkg::E_SRCH, bpa_pkg::E_POP_WAIT: hd_ridx = o_ff;
         bpa_pkg::E_SPLIT:                     hd_ridx = o_ff - 1'b1;
         bpa_pkg::E_ADD:                       hd_ridx = OW'(aord);
         default:                              hd_ridx = ord_ff;
      endcase
   end
   assign hd_rframe = head_ff[hd_ridx];
   assign hd_rlen   = len_ff[hd_ridx];

   // Sequencer
   logic [31:0]   np_ord, bud32, lim32, a32, m32, np_add, base32;
   logic          do_push, merged;
   logic [FW-1:0] push_frame;
   bpa_pkg::eng_state_type fill_done_state;

   always_comb begin
      np_ord = 32'd1 << ord_ff;
      base32 = 32'(base_ff);
      bud32  = base32 ^ np_ord;
      lim32  = 32'(lim);
      a32    = 32'(alloc_cnt_ff);
      m32    = 32'(managed_cnt_ff);
      np_add = 32'd1 << aord;
      case (kind_ff)
         bpa_pkg::CMD_ALLOC: fill_done_state = bpa_pkg::E_DONE;
         bpa_pkg::CMD_FREE:  fill_done_state = bpa_pkg::E_MERGE;
         default:            fill_done_state = bpa_pkg::E_ADD;
      endcase

      state_in       = state_ff;
      kind_in        = kind_ff;
      status_in      = status_ff;
      w_in           = w_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      fill_one_in    = fill_one_ff;
      base_in        = base_ff;
      ord_in         = ord_ff;
      o_in           = o_ff;
      buddy_in       = buddy_ff;
      prev_in        = prev_ff;
      idx_in         = idx_ff;
      f_in           = f_ff;
      end_in         = end_ff;
      res_frame_in   = res_frame_ff;
      alloc_cnt_in   = alloc_cnt_ff;
      managed_cnt_in = managed_cnt_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_status_in  = rsp_status_ff;
      rsp_frame_in   = rsp_frame_ff;
      rsp_free_in    = rsp_free_ff;
      rsp_managed_in = rsp_managed_ff;
      cmd_ready      = 1'b0;
      bm_we          = 1'b0;
      bm_waddr       = w_ff;
      bm_wdata       = '0;
      bm_raddr       = w_ff;
      lk_we          = 1'b0;
      lk_waddr       = prev_ff;
      lk_wdata       = lk_rdata_ff;
      lk_raddr       = prev_ff;
      hd_we          = 1'b0;
      hd_widx        = hd_ridx;
      hd_wframe      = hd_rframe;
      hd_wlen        = hd_rlen;
      do_push        = 1'b0;
      push_frame     = base_ff;
      merged         = 1'b0;

      case (state_ff)
         // Set every bitmap word after reset
         bpa_pkg::E_INIT: begin
            bm_we    = 1'b1;
            bm_wdata = '1;
            if (w_ff == WAW'(NW - 1)) state_in = bpa_pkg::E_IDLE;
            else w_in = w_ff + 1'b1;
         end
         bpa_pkg::E_IDLE: begin
            if (cmd_valid && !rsp_valid_ff) begin
               cmd_ready    = 1'b1;
               kind_in      = cmd.kind;
               status_in    = cmd.status;
               ord_in       = OW'(cmd.ord);
               o_in         = OW'(cmd.ord);
               base_in      = FW'(cmd.frame);
               f_in         = CW'(cmd.frame);
               end_in       = CW'(cmd.end_frame);
               res_frame_in = '0;
               lo_in        = FW'(cmd.frame);
               fill_one_in  = 1'b0;
               w_in         = WAW'(cmd.frame >> bpa_pkg::WORD_SH);
               case (cmd.kind)
                  bpa_pkg::CMD_ALLOC: state_in = bpa_pkg::E_SRCH;
                  bpa_pkg::CMD_FREE: begin
                     hi_in        = CW'(32'(cmd.frame) + (32'd1 << cmd.ord));
                     alloc_cnt_in = (a32 > (32'd1 << cmd.ord))
                                    ? CW'(a32 - (32'd1 << cmd.ord)) : '0;
                     state_in     = bpa_pkg::E_FILL;
                  end
                  bpa_pkg::CMD_ADD: begin
                     hi_in    = CW'(cmd.end_frame);
                     state_in = bpa_pkg::E_FILL;
                  end
                  default: state_in = bpa_pkg::E_DONE;
               endcase
            end
         end
         // Smallest non-empty order at or above the request
         bpa_pkg::E_SRCH: begin
            if (hd_rlen != 32'd0) begin
               base_in  = hd_rframe;
               lk_raddr = hd_rframe;
               state_in = bpa_pkg::E_POP_WAIT;
            end else if (o_ff == OW'(TOP_ORDER)) begin
               status_in = bpa_pkg::ST_NO_BLOCK;
               state_in  = bpa_pkg::E_DONE;
            end else begin
               o_in = o_ff + 1'b1;
            end
         end
         bpa_pkg::E_POP_WAIT: begin
            hd_we     = 1'b1;
            hd_wframe = lk_rdata_ff;
            hd_wlen   = hd_rlen - 32'd1;
            state_in  = bpa_pkg::E_SPLIT;
         end
         // Push upper halves down to the wanted order
         bpa_pkg::E_SPLIT: begin
            if (o_ff > ord_ff) begin
               o_in       = o_ff - 1'b1;
               do_push    = 1'b1;
               push_frame = FW'(base32 + (32'd1 << (o_ff - 1'b1)));
            end else begin
               lo_in        = base_ff;
               hi_in        = CW'(base32 + np_ord);
               fill_one_in  = 1'b1;
               w_in         = base_ff[FW-1:bpa_pkg::WORD_SH];
               res_frame_in = base_ff;
               alloc_cnt_in = (a32 + np_ord > 32'(NUM_FRAMES))
                              ? CW'(NUM_FRAMES) : CW'(a32 + np_ord);
               state_in     = bpa_pkg::E_FILL;
            end
         end
         // Bitmap range write, read-modify-write on partial words
         bpa_pkg::E_FILL, bpa_pkg::E_FILL_WR: begin
            if (state_ff == bpa_pkg::E_FILL && mask != '1) begin
               state_in = bpa_pkg::E_FILL_WR;
            end else begin
               bm_we = 1'b1;
               if (state_ff == bpa_pkg::E_FILL) bm_wdata = fill_one_ff ? '1 : '0;
               else bm_wdata = fill_one_ff ? (bm_rdata_ff | mask) : (bm_rdata_ff & ~mask);
               if (fill_last) begin
                  state_in = fill_done_state;
               end else begin
                  w_in     = w_ff + 1'b1;
                  state_in = bpa_pkg::E_FILL;
               end
            end
         end
         // Try to merge with the buddy
         bpa_pkg::E_MERGE: begin
            if (ord_ff == OW'(TOP_ORDER) || bud32 + np_ord > lim32) begin
               state_in = bpa_pkg::E_PUSH;
            end else begin
               buddy_in = FW'(bud32);
               lo_in    = FW'(bud32);
               hi_in    = CW'(bud32 + np_ord);
               w_in     = WAW'(bud32 >> bpa_pkg::WORD_SH);
               state_in = bpa_pkg::E_SCAN_RD;
            end
         end
         bpa_pkg::E_SCAN_RD: state_in = bpa_pkg::E_SCAN_CHK;
         bpa_pkg::E_SCAN_CHK: begin
            if ((bm_rdata_ff & mask) != '0) begin
               state_in = bpa_pkg::E_PUSH;
            end else if (fill_last) begin
               state_in = bpa_pkg::E_RM;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = bpa_pkg::E_SCAN_RD;
            end
         end
         // Find and unlink the buddy in its list
         bpa_pkg::E_RM: begin
            if (hd_rlen == 32'd0) begin
               state_in = bpa_pkg::E_PUSH;
            end else if (hd_rframe == buddy_ff) begin
               lk_raddr = buddy_ff;
               state_in = bpa_pkg::E_RM_HEAD;
            end else begin
               prev_in = hd_rframe;
               idx_in  = 32'd1;
               if (hd_rlen > 32'd1) begin
                  lk_raddr = hd_rframe;
                  state_in = bpa_pkg::E_RM_CHK;
               end else begin
                  state_in = bpa_pkg::E_PUSH;
               end
            end
         end
         bpa_pkg::E_RM_HEAD: begin
            hd_we     = 1'b1;
            hd_wframe = lk_rdata_ff;
            hd_wlen   = hd_rlen - 32'd1;
            merged    = 1'b1;
         end
         bpa_pkg::E_RM_CHK: begin
            if (lk_rdata_ff == buddy_ff) begin
               lk_raddr = lk_rdata_ff;
               state_in = bpa_pkg::E_RM_UNLINK;
            end else begin
               prev_in = lk_rdata_ff;
               idx_in  = idx_ff + 32'd1;
               if (idx_ff + 32'd1 < hd_rlen) lk_raddr = lk_rdata_ff;
               else state_in = bpa_pkg::E_PUSH;
            end
         end
         bpa_pkg::E_RM_UNLINK: begin
            lk_we    = 1'b1;
            lk_waddr = prev_ff;
            lk_wdata = lk_rdata_ff;
            hd_we    = 1'b1;
            hd_wlen  = hd_rlen - 32'd1;
            merged   = 1'b1;
         end
         bpa_pkg::E_PUSH: begin
            do_push  = 1'b1;
            state_in = bpa_pkg::E_DONE;
         end
         // Carve the region into maximal aligned blocks
         bpa_pkg::E_ADD: begin
            if (f_ff >= end_ff) begin
               state_in = bpa_pkg::E_DONE;
            end else begin
               do_push        = 1'b1;
               push_frame     = FW'(f_ff);
               managed_cnt_in = (m32 + np_add > 32'(NUM_FRAMES))
                                ? CW'(NUM_FRAMES) : CW'(m32 + np_add);
               f_in           = CW'(32'(f_ff) + np_add);
            end
         end
         bpa_pkg::E_DONE: begin
            rsp_valid_in   = 1'b1;
            rsp_status_in  = status_ff;
            rsp_frame_in   = res_frame_ff[15:0];
            rsp_free_in    = (managed_cnt_ff > alloc_cnt_ff)
                             ? 17'(managed_cnt_ff - alloc_cnt_ff) : 17'd0;
            rsp_managed_in = 17'(managed_cnt_ff);
            state_in       = bpa_pkg::E_IDLE;
         end
         default: state_in = bpa_pkg::E_IDLE;
      endcase

      // Push onto the head of the list at hd_ridx
      if (do_push) begin
         lk_we     = 1'b1;
         lk_waddr  = push_frame;
         lk_wdata  = hd_rframe;
         hd_we     = 1'b1;
         hd_wframe = push_frame;
         hd_wlen   = (hd_rlen == 32'hFFFF_FFFF) ? hd_rlen : hd_rlen + 32'd1;
      end

      // Buddy taken out: grow the block one order
      if (merged) begin
         if (buddy_ff < base_ff) base_in = buddy_ff;
         ord_in   = ord_ff + 1'b1;
         state_in = bpa_pkg::E_MERGE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= bpa_pkg::E_INIT;
         w_ff           <= '0;
         alloc_cnt_ff   <= '0;
         managed_cnt_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         w_ff           <= w_in;
         alloc_cnt_ff   <= alloc_cnt_in;
         managed_cnt_ff <= managed_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      status_ff      <= status_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      fill_one_ff    <= fill_one_in;
      base_ff        <= base_in;
      ord_ff         <= ord_in;
      o_ff           <= o_in;
      buddy_ff       <= buddy_in;
      prev_ff        <= prev_in;
      idx_ff         <= idx_in;
      f_ff           <= f_in;
      end_ff         <= end_in;
      res_frame_ff   <= res_frame_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_frame_ff   <= rsp_frame_in;
      rsp_free_ff    <= rsp_free_in;
      rsp_managed_ff <= rsp_managed_in;
   end

   // List heads, all empty after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HN; i++) begin
            head_ff[i] <= '0;
            len_ff[i]  <= '0;
         end
      end else if (hd_we) begin
         head_ff[hd_widx] <= hd_wframe;
         len_ff[hd_widx]  <= hd_wlen;
      end
   end

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
      bm_rdata_ff <= bm_mem[bm_raddr];
   end

   always_ff @(posedge clock) begin
      if (lk_we) lk_mem[lk_waddr] <= lk_wdata;
      lk_rdata_ff <= lk_mem[lk_raddr];
   end

   assign init_busy         = (state_ff == bpa_pkg::E_INIT);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_alloc_frame   = rsp_frame_ff;
   assign rsp_free_pages    = rsp_free_ff;
   assign rsp_managed_pages = rsp_managed_ff;

endmodule

@@ rtl/buddy_page_allocator.sv @@
// Buddy page allocator.
// Request beats (req_*) carry allocate, free or add-region work; each one
// returns exactly one response beat (rsp_*) with status, allocated base
// frame and the free and managed page counts after that request.
// csr_we/csr_wdata write the tracked frame limit; write only while idle.
// A front end classifies beats into a two-entry queue; the engine behind it
// walks the bitmap and the free lists, so up to two beats are taken while a
// response waits for rsp_ready. The response is held until taken.
// Throughput: one request at a time; the engine starts the next one only
// after the previous response has been taken.
// Rejected and unknown requests skip the bitmap and the lists. Real work
// is set by the bitmap port: whole 32-frame words are written directly,
// partial words by read-modify-write, and words are checked one by one;
// it also grows with the list links followed when removing a buddy, the
// orders searched or split and the blocks pushed.
// Reset: a clearing pass marks every frame allocated; req_ready stays low
// until it ends. Lists start empty and both page counts at zero.
module buddy_page_allocator #(
   parameter int NUM_FRAMES = 65536,
   parameter int TOP_ORDER  = 15
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_page_count,
   input  logic [15:0] req_frame,
   input  logic [16:0] req_end_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [15:0] rsp_alloc_frame,
   output logic [16:0] rsp_free_pages,
   output logic [16:0] rsp_managed_pages,
   input  logic        csr_we,
   input  logic [16:0] csr_wdata
);

   localparam int FW = $clog2(NUM_FRAMES);
   localparam int CW = FW + 1;
   localparam int LW = (CW > 17) ? CW : 17;

   logic [16:0]      tracked_ff;
   logic [LW-1:0]    trk_w, lim_full;
   logic [CW-1:0]    lim;
   logic             cmd_valid, cmd_ready, init_busy;
   bpa_pkg::cmd_type cmd;

   // Tracked frame limit
   always_ff @(posedge clock) begin
      if (reset) tracked_ff <= 17'd65536;
      else if (csr_we) tracked_ff <= csr_wdata;
   end

   assign trk_w    = LW'(tracked_ff);
   assign lim_full = (trk_w < LW'(NUM_FRAMES)) ? trk_w : LW'(NUM_FRAMES);
   assign lim      = CW'(lim_full);

   bpa_front #(
      .NUM_FRAMES (NUM_FRAMES),
      .TOP_ORDER  (TOP_ORDER)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_page_count (req_page_count),
      .req_frame      (req_frame),
      .req_end_frame  (req_end_frame),
      .lim            (lim),
      .init_busy      (init_busy),
      .cmd_valid      (cmd_valid),
      .cmd_ready      (cmd_ready),
      .cmd            (cmd)
   );

   bpa_engine #(
      .NUM_FRAMES (NUM_FRAMES),
      .TOP_ORDER  (TOP_ORDER)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .lim               (lim),
      .cmd_valid         (cmd_valid),
      .cmd_ready         (cmd_ready),
      .cmd               (cmd),
      .init_busy         (init_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_alloc_frame   (rsp_alloc_frame),
      .rsp_free_pages    (rsp_free_pages),
      .rsp_managed_pages (rsp_managed_pages)
   );

endmodule

@@ rtl/bpa_checker.sv @@
module bpa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_status,
   input logic [15:0] rsp_alloc_frame,
   input logic [16:0] rsp_free_pages,
   input logic [16:0] rsp_managed_pages
);

   // Clearing pass holds off requests after reset
   a_init_block: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request taken or response shown straight after reset");

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_alloc_frame) && $stable(rsp_free_pages)
         && $stable(rsp_managed_pages))
      else $error("response beat changed while stalled");

   // Free pages never exceed managed pages
   a_free_le_managed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_free_pages <= rsp_managed_pages)
      else $error("free pages above managed pages");

   // Base frame only reported on success
   a_frame_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 2'(bpa_pkg::ST_DONE) |-> rsp_alloc_frame == 16'd0)
      else $error("frame reported on a failed request");

   // Managed count never drops between beats
   a_managed_grows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready ##1 rsp_valid |-> rsp_managed_pages >= $past(rsp_managed_pages))
      else $error("managed page count went down");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
